/* rtl/ita_pkg.sv */
// ----------------------------------------------------------------------------
// ita_pkg
// Shared types, codes and character constants for the integer to ASCII
// formatter: format selector codes, ASCII constants, digit lookup.
// ----------------------------------------------------------------------------
package ita_pkg;

   // Format selector codes
   localparam logic [1:0] OP_DEC       = 2'd0;
   localparam logic [1:0] OP_HEX_LOWER = 2'd1;
   localparam logic [1:0] OP_HEX_UPPER = 2'd2;
   localparam logic [1:0] OP_POINTER   = 2'd3;

   // Field widths
   localparam int OP_W        = 2;
   localparam int CHAR_W      = 7;
   localparam int COUNT_W     = 5;
   localparam int MAX_CHARS   = 20;
   localparam int REQ_DATA_W  = 64;
   localparam int RSP_DATA_W  = 16;

   // ASCII constants
   localparam logic [6:0] CHAR_ZERO    = 7'h30;
   localparam logic [6:0] CHAR_X       = 7'h78;
   localparam logic [6:0] CHAR_MINUS   = 7'h2D;
   localparam logic [6:0] CHAR_UPPER_A = 7'h41;
   localparam logic [6:0] CHAR_LOWER_A = 7'h61;

   // Load command from the top level to the character emitter
   typedef struct packed {
      logic       load;
      logic [1:0] op;
      logic       neg;
   } ita_load_type;

   // One digit (0..15) to its ASCII character
   function automatic logic [6:0] digit_char(input logic [3:0] d, input logic upper);
      logic [6:0] base;
      base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
      if (d < 4'd10) begin
         return CHAR_ZERO + {3'b000, d};
      end
      return base + {3'b000, d} - 7'd10;
   endfunction

endpackage

/* rtl/ita_bcd_conv.sv */
// ----------------------------------------------------------------------------
// ita_bcd_conv
// Bit-serial binary to BCD converter (shift and add-3). One input bit enters
// the BCD register per cycle; done pulses once all WIDTH bits have been shifted in.
// ----------------------------------------------------------------------------
module ita_bcd_conv #(
   parameter int WIDTH = 64,
   parameter int NDIG  = 20
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [WIDTH-1:0]    magnitude,
   output logic                done,
   output logic [NDIG*4-1:0]   digits
);

   localparam int CW = $clog2(WIDTH + 1);
   localparam int DW = NDIG * 4;

   logic [WIDTH-1:0] bin_ff, bin_in;
   logic [DW-1:0]    bcd_ff, bcd_in;
   logic [DW-1:0]    adj;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   // Add 3 to every BCD digit of 5 or more before the shift
   always_comb begin
      for (int i = 0; i < NDIG; i++) begin
         adj[i*4 +: 4] = (bcd_ff[i*4 +: 4] >= 4'd5) ? bcd_ff[i*4 +: 4] + 4'd3
                                                    : bcd_ff[i*4 +: 4];
      end
   end

   // Sequencer: load, then shift one bit per cycle
   always_comb begin
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         bin_in  = magnitude;
         bcd_in  = '0;
         cnt_in  = CW'(WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         bcd_in = {adj[DW-2:0], bin_ff[WIDTH-1]};
         bin_in = bin_ff << 1;
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign done   = done_ff;
   assign digits = bcd_ff;

endmodule

/* rtl/ita_emit.sv */
// ----------------------------------------------------------------------------
// ita_emit
// Character emitter: drops leading zero digits one per cycle, then sends the
// prefix and one digit per item from a nibble shift register into the output
// register.
// ----------------------------------------------------------------------------
module ita_emit #(
   parameter int NDIG = 20
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ita_pkg::ita_load_type         ld,
   input  logic [NDIG*4-1:0]             digits,
   output logic                          busy,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [ita_pkg::CHAR_W-1:0]    rsp_char,
   output logic                          rsp_last,
   output logic [ita_pkg::COUNT_W-1:0]   rsp_total
);

   localparam int CW = $clog2(NDIG + 1);
   localparam int DW = NDIG * 4;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SKIP   = 2'd1;
   localparam logic [1:0] ST_PREFIX = 2'd2;
   localparam logic [1:0] ST_DIGITS = 2'd3;

   logic [1:0]                    state_ff, state_in;
   logic [DW-1:0]                 dig_ff, dig_in;
   logic [CW-1:0]                 rem_ff, rem_in;
   logic                          idx_ff, idx_in;
   logic [ita_pkg::COUNT_W-1:0]   total_ff, total_in;
   logic [1:0]                    op_ff, op_in;
   logic                          neg_ff, neg_in;
   logic                          out_valid_ff, out_valid_in;
   logic [ita_pkg::CHAR_W-1:0]    out_char_ff, out_char_in;
   logic                          out_last_ff, out_last_in;
   logic [ita_pkg::COUNT_W-1:0]   out_total_ff, out_total_in;

   logic [1:0] prefix_len;
   logic [3:0] top_nib;
   logic       adv;
   logic       upper;
   logic       fin;

   // Prefix length: '-' for negative decimal, "0x" for pointer form
   always_comb begin
      prefix_len = 2'd0;
      if (op_ff == ita_pkg::OP_DEC) begin
         prefix_len = {1'b0, neg_ff};
      end else if (op_ff == ita_pkg::OP_POINTER) begin
         prefix_len = 2'd2;
      end
   end

   assign top_nib = dig_ff[DW-1 -: 4];
   assign adv     = !out_valid_ff || rsp_ready;
   assign upper   = (op_ff == ita_pkg::OP_HEX_UPPER) || (op_ff == ita_pkg::OP_DEC);
   assign fin     = (rem_ff == CW'(1));

   // Emitter sequencer
   always_comb begin
      state_in     = state_ff;
      dig_in       = dig_ff;
      rem_in       = rem_ff;
      idx_in       = idx_ff;
      total_in     = total_ff;
      op_in        = op_ff;
      neg_in       = neg_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      out_total_in = out_total_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (ld.load) begin
               dig_in   = digits;
               rem_in   = CW'(NDIG);
               op_in    = ld.op;
               neg_in   = ld.neg;
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            // drop leading zeros, keep at least one digit
            if (top_nib == 4'd0 && !fin) begin
               dig_in = dig_ff << 4;
               rem_in = rem_ff - CW'(1);
            end else begin
               total_in = ita_pkg::COUNT_W'(rem_ff) + {3'b000, prefix_len};
               idx_in   = 1'b0;
               state_in = (prefix_len != 2'd0) ? ST_PREFIX : ST_DIGITS;
            end
         end
         ST_PREFIX: begin
            if (adv) begin
               out_valid_in = 1'b1;
               out_last_in  = 1'b0;
               out_total_in = '0;
               if (op_ff == ita_pkg::OP_DEC) begin
                  out_char_in = ita_pkg::CHAR_MINUS;
               end else begin
                  out_char_in = idx_ff ? ita_pkg::CHAR_X : ita_pkg::CHAR_ZERO;
               end
               idx_in = 1'b1;
               if (idx_ff || prefix_len == 2'd1) begin
                  state_in = ST_DIGITS;
               end
            end
         end
         ST_DIGITS: begin
            if (adv) begin
               out_valid_in = 1'b1;
               out_char_in  = ita_pkg::digit_char(top_nib, upper);
               out_last_in  = fin;
               out_total_in = fin ? total_ff : '0;
               dig_in       = dig_ff << 4;
               rem_in       = rem_ff - CW'(1);
               if (fin) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      dig_ff       <= dig_in;
      rem_ff       <= rem_in;
      idx_ff       <= idx_in;
      total_ff     <= total_in;
      op_ff        <= op_in;
      neg_ff       <= neg_in;
      out_char_ff  <= out_char_in;
      out_last_ff  <= out_last_in;
      out_total_ff <= out_total_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = out_valid_ff;
   assign rsp_char  = out_char_ff;
   assign rsp_last  = out_last_ff;
   assign rsp_total = out_total_ff;

endmodule

/* rtl/integer_to_ascii_formatter.sv */
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// Prints one number per request item as a stream of ASCII characters.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: req_tdata holds the value (low VALUE_WIDTH bits used),
//   req_tuser the format (signed decimal, hex lower, hex upper, pointer).
//   Response channel: one item per character, most significant first;
//   rsp_tlast marks the final character, which also carries the character
//   count in rsp_tdata[11:7] (zero on all other characters).
// Sequence (receiver always ready):
//   Decimal: bit-serial BCD conversion, a load into the emitter, leading
//   zero digits dropped one per cycle, a decision step, the prefix
//   characters, the printed digits one per cycle and a step back to idle.
//   Hex skips the conversion and loads the value at once; pointer form
//   adds the "0x" prefix.
//   One number is worked on at a time; req_tready rises in the cycle
//   after the last character has entered the output register, even if it
//   is not taken.
// Reset clears the sequencers and the output valid; no number is in flight.
// A stalled receiver holds the output register and freezes the emitter's prefix and digit steps.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter #(
   parameter int VALUE_WIDTH = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [ita_pkg::REQ_DATA_W-1:0]    req_tdata,  // [63:0] value
   input  logic [ita_pkg::OP_W-1:0]          req_tuser,  // [1:0] operation
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [ita_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // [6:0] character, [11:7] total_count
   output logic                              rsp_tlast
);

   localparam int NDIG = (VALUE_WIDTH * 30103) / 100000 + 1;
   localparam int DW   = NDIG * 4;
   localparam int PAD  = ita_pkg::RSP_DATA_W - ita_pkg::CHAR_W - ita_pkg::COUNT_W;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]               state_ff, state_in;
   logic [1:0]               op_ff, op_in;
   logic                     neg_ff, neg_in;

   logic                     accept;
   logic [VALUE_WIDTH-1:0]   val;
   logic [VALUE_WIDTH-1:0]   mag;
   logic                     neg;
   logic                     is_dec;
   logic                     conv_start;
   logic                     conv_done;
   logic [DW-1:0]            bcd;
   ita_pkg::ita_load_type    ld;
   logic [DW-1:0]            ld_digits;
   logic                     emit_busy;
   logic [ita_pkg::CHAR_W-1:0]  rsp_char;
   logic [ita_pkg::COUNT_W-1:0] rsp_total;

   // Input decode: sign and magnitude for decimal
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign val        = req_tdata[VALUE_WIDTH-1:0];
   assign is_dec     = (req_tuser == ita_pkg::OP_DEC);
   assign neg        = is_dec && val[VALUE_WIDTH-1];
   assign mag        = neg ? (~val + VALUE_WIDTH'(1)) : val;
   assign conv_start = accept && is_dec;

   // Top sequencer: decimal goes through the converter, hex loads directly
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      neg_in       = neg_ff;
      ld.load      = 1'b0;
      ld.op        = op_ff;
      ld.neg       = neg_ff;
      ld_digits    = bcd;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in  = req_tuser;
               neg_in = neg;
               if (is_dec) begin
                  state_in = ST_CONV;
               end else begin
                  ld.load   = 1'b1;
                  ld.op     = req_tuser;
                  ld.neg    = 1'b0;
                  ld_digits = DW'(val);
                  state_in  = ST_EMIT;
               end
            end
         end
         ST_CONV: begin
            if (conv_done) begin
               ld.load  = 1'b1;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!emit_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      op_ff  <= op_in;
      neg_ff <= neg_in;
   end

   ita_bcd_conv #(
      .WIDTH (VALUE_WIDTH),
      .NDIG  (NDIG)
   ) u_conv (
      .clock     (clock),
      .reset     (reset),
      .start     (conv_start),
      .magnitude (mag),
      .done      (conv_done),
      .digits    (bcd)
   );

   ita_emit #(
      .NDIG (NDIG)
   ) u_emit (
      .clock     (clock),
      .reset     (reset),
      .ld        (ld),
      .digits    (ld_digits),
      .busy      (emit_busy),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_char  (rsp_char),
      .rsp_last  (rsp_tlast),
      .rsp_total (rsp_total)
   );

   assign rsp_tdata = {{PAD{1'b0}}, rsp_total, rsp_char};

`ifndef SYNTHESIS
   // Emitter is never busy while a new number can be accepted
   a_idle_emit : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !emit_busy)
      else $error("emitter busy while idle");

   // Converter finishes only while a decimal number is being converted
   a_conv_done : assert property (@(posedge clock) disable iff (reset)
      conv_done |-> (state_ff == ST_CONV))
      else $error("converter done outside conversion");

   // Final character carries a count between 1 and the maximum
   a_last_count : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |->
         (rsp_total != '0 && rsp_total <= ita_pkg::COUNT_W'(ita_pkg::MAX_CHARS)))
      else $error("bad character count on last");

   // Count is zero on every other character
   a_mid_count : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |-> (rsp_total == '0))
      else $error("count set before last character");
`endif

endmodule

/* tb/sv/integer_to_ascii_formatter_tb.sv */
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_tb
// Self-checking bench for the integer to ASCII formatter. Numbers go in on
// the request stream with random gaps. A directed set covers zero, all ones
// and the most negative value in every format, and decimal digit-count boundaries. A
// random set follows with mixed value shapes. Every character item is checked
// against a local predictor while the receiver stalls at random. It also holds
// off once for a long stretch, so the block backs up into its request side.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_RANDOM   = 444;
   // Limit sized for the slowest run: the block's own work, a receiver stall
   // after every character and a long sender gap, for each of about 470
   // numbers, plus the hold-off.
   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam int DRAIN_CYCLES = 150;

   // Digit sets, first character in the top byte
   localparam logic [8*16-1:0] DIGITS_LOWER = "0123456789abcdef";
   localparam logic [8*16-1:0] DIGITS_UPPER = "0123456789ABCDEF";

   typedef struct packed {
      logic [ita_pkg::RSP_DATA_W-1:0] data;
      logic                           last;
   } char_item_type;

   // Expected character stream, filled per accepted number
   class char_scoreboard;
      char_item_type expected_chars[$];
      int unsigned   mismatches;

      function new();
         mismatches = 0;
      endfunction

      function logic [6:0] digit_ascii(logic [3:0] d, logic upper);
         logic [7:0] ch;
         ch = upper ? DIGITS_UPPER[8*(15-d) +: 8] : DIGITS_LOWER[8*(15-d) +: 8];
         return ch[6:0];
      endfunction

      // Work out the characters one number prints and queue them
      function void note_number(logic [1:0] fmt, logic [63:0] value);
         logic [6:0]    text [ita_pkg::MAX_CHARS];
         logic [6:0]    rev [ita_pkg::MAX_CHARS];
         logic [63:0]   mag;
         logic [63:0]   radix;
         logic          upper;
         logic [4:0]    cnt;
         char_item_type item;
         int            len;
         int            nd;
         int            i;
         len   = 0;
         mag   = value;
         upper = (fmt == ita_pkg::OP_HEX_UPPER);
         radix = (fmt == ita_pkg::OP_DEC) ? 64'd10 : 64'd16;
         case (fmt)
            ita_pkg::OP_DEC: begin
               // two's complement; the most negative value keeps its magnitude
               if (value[63]) begin
                  mag = 64'd0 - value;
                  text[len] = ita_pkg::CHAR_MINUS;
                  len++;
               end
            end
            ita_pkg::OP_POINTER: begin
               text[0] = ita_pkg::CHAR_ZERO;
               text[1] = ita_pkg::CHAR_X;
               len = 2;
            end
            default: ;
         endcase
         nd = 0;
         do begin
            rev[nd] = digit_ascii(4'(mag % radix), upper);
            mag = mag / radix;
            nd++;
         end while (mag != 0 && nd < ita_pkg::MAX_CHARS);
         for (i = nd - 1; i >= 0 && len < ita_pkg::MAX_CHARS; i--) begin
            text[len] = rev[i];
            len++;
         end
         cnt = 5'(len);
         for (i = 0; i < len; i++) begin
            item.last = (i == len - 1);
            item.data = {4'b0000, item.last ? cnt : 5'd0, text[i]};
            expected_chars.push_back(item);
         end
      endfunction

      // Compare one accepted character item with the oldest expectation
      function void check_char(logic [ita_pkg::RSP_DATA_W-1:0] data, logic last);
         char_item_type want;
         if (expected_chars.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected item: char %h count %0d last %b",
                        data[6:0], data[11:7], last);
            return;
         end
         want = expected_chars.pop_front();
         if (data !== want.data || last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"mismatch: expected char %h count %0d last %b pad %h,",
                         " got char %h count %0d last %b pad %h"},
                        want.data[6:0], want.data[11:7], want.last, want.data[15:12],
                        data[6:0], data[11:7], last, data[15:12]);
         end
      endfunction

      function int pending();
         return expected_chars.size();
      endfunction

      function bit passed();
         return mismatches == 0 && expected_chars.size() == 0;
      endfunction
   endclass

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [ita_pkg::REQ_DATA_W-1:0] req_tdata  = '0;  // [63:0] value
   logic [ita_pkg::OP_W-1:0]       req_tuser  = '0;  // [1:0] operation
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [ita_pkg::RSP_DATA_W-1:0] rsp_tdata;  // [6:0] character, [11:7] total_count
   logic                           rsp_tlast;

   logic                           hold_off    = 1'b0;
   int                             stall_left  = 0;
   int                             cycle_count = 0;
   char_scoreboard                 sb;

   integer_to_ascii_formatter #(.VALUE_WIDTH(64)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Random value shapes: full width, short, negated short, near powers of ten
   function automatic logic [63:0] pick_value();
      logic [63:0] v;
      logic [63:0] p;
      int          kind;
      kind = $urandom_range(0, 9);
      v = {$urandom, $urandom};
      case (kind)
         0, 1, 2: ;
         3, 4, 5: v = v >> $urandom_range(0, 63);
         6, 7:    v = 64'd0 - (v >> $urandom_range(1, 63));
         default: begin
            p = 64'd1;
            repeat ($urandom_range(0, 19)) p = p * 64'd10;
            v = p + 64'($urandom_range(0, 2)) - 64'd1;
            if ($urandom_range(0, 1) == 1) v = 64'd0 - v;
         end
      endcase
      return v;
   endfunction

   // Offer one number after an idle gap and wait until it is taken
   task automatic send_number(logic [1:0] fmt, logic [63:0] value, int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= fmt;
      do @(posedge clock); while (!req_tready);
      sb.note_number(fmt, value);
   endtask

   // Receiver: random stalls after items, a no-stall stretch now and then
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (hold_off) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (rsp_tvalid && rsp_tready && cycle_count[10:9] != 2'b11) begin
         stall_left <= pick_gap();
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_char(rsp_tdata, rsp_tlast);
   end

   // Long receiver hold-off while numbers keep coming
   initial begin
      repeat (3000) @(posedge clock);
      hold_off <= 1'b1;
      repeat (400) @(posedge clock);
      hold_off <= 1'b0;
   end

   // Watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count <= cycle_count + 1;
      end
      $display("Simulation FAILED");
      $finish;
   end

   // Stimulus
   initial begin
      logic [63:0] corner_values [5];
      int          k;
      int          j;
      int          gap;
      sb = new();
      corner_values[0] = 64'h0000_0000_0000_0000;
      corner_values[1] = 64'hFFFF_FFFF_FFFF_FFFF;
      corner_values[2] = 64'h8000_0000_0000_0000;
      corner_values[3] = 64'h7FFF_FFFF_FFFF_FFFF;
      corner_values[4] = 64'h0123_4567_89AB_CDEF;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: corners in every format, then digit boundaries
      for (k = 0; k < 4; k++)
         for (j = 0; j < 5; j++)
            send_number(2'(k), corner_values[j], pick_gap());
      send_number(ita_pkg::OP_DEC, 64'd9, 0);
      send_number(ita_pkg::OP_DEC, 64'd10, 1);
      send_number(ita_pkg::OP_DEC, 64'hFFFF_FFFF_FFFF_FFF6, 0);
      send_number(ita_pkg::OP_DEC, 64'd999_999_999_999_999_999, 2);
      send_number(ita_pkg::OP_HEX_LOWER, 64'hFEDC_BA98_7654_3210, 0);
      send_number(ita_pkg::OP_HEX_UPPER, 64'hFEDC_BA98_7654_3210, 0);

      // Random numbers, with back-to-back stretches
      for (k = 0; k < NUM_RANDOM; k++) begin
         gap = ((k / 60) % 3 == 1) ? 0 : pick_gap();
         send_number(2'($urandom_range(0, 3)), pick_value(), gap);
      end
      req_tvalid <= 1'b0;

      // Drain
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.passed())
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
